// ===== rtl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frame statistics collector
// Command codes, field widths, gap bin thresholds and the control bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package fsc_pkg;

	// command codes
	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// field widths
	localparam int CMD_W  = 2;
	localparam int TIME_W = 63;
	localparam int CNT_W  = 32;
	localparam int RSSI_W = 8;
	localparam int MODE_W = 2;
	localparam int RATE_W = 8;
	localparam int IDX_W  = 9;

	// fixed counter groups
	localparam int MODE_N = 4;
	localparam int ANT_N  = 2;

	// RSSI extremes after clear
	localparam logic signed [RSSI_W-1:0] RSSI_MIN_INIT = 8'sh7F;
	localparam logic signed [RSSI_W-1:0] RSSI_MAX_INIT = 8'sh80;

	// gap bin thresholds in us; beyond the ninth they repeat the last one
	localparam int THR_W = 26;
	localparam int THR_N = 16;
	localparam logic [THR_W-1:0] GAP_THR [THR_N] = '{
		26'd50000,    26'd100000,   26'd500000,   26'd1000000,
		26'd2000000,  26'd5000000,  26'd10000000, 26'd30000000,
		26'd60000000, 26'd60000000, 26'd60000000, 26'd60000000,
		26'd60000000, 26'd60000000, 26'd60000000, 26'd60000000
	};

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // request taken: register it, start the counter read
		logic commit;   // update the statistics and load the result register
	} fsc_ctrl_t;

endpackage

// ===== rtl/frame_statistics_collector_unit.sv =====
// ----------------------------------------------------------------------------
// frame_statistics_collector_unit: received frame statistics collector
// Counts frames, RSSI extremes, per-mode, per-antenna and per-rate counts
// and a histogram of inter-frame gaps; serves counter reads and clears.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (in_valid/in_stall): command plus frame fields. A request
//  is taken when in_valid is high and in_stall low. Record, read, clear;
//  code 3 changes nothing. Every request gives exactly one result.
//  Result channel (out_valid/out_stall): read_value (zero unless a read),
//  total_frames and the RSSI extremes as they stand after the request.
//  A taken request is registered at capture, its result at commit. No new
//  request is taken before that commit, as set by the read-modify-write of
//  the rate counter memory (read at capture, write at commit).
//  A stalled result holds in the result register; the block then finishes
//  the next request up to its commit and stalls the request side until the
//  result register frees.
//  Reset (arst_n low) clears every counter and extreme at once: the rate
//  memory has a valid bit per entry, so there is no clearing sweep. A clear
//  request does the same in its commit cycle.
// ----------------------------------------------------------------------------
module frame_statistics_collector_unit import fsc_pkg::*; #(
	parameter int INTERVAL_BINS = 10,
	parameter int RATE_CODES    = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic [TIME_W-1:0]        timestamp_us,
	input  logic signed [RSSI_W-1:0] rssi_dbm,
	input  logic [MODE_W-1:0]        signal_mode,
	input  logic [RATE_W-1:0]        rate_code,
	input  logic                     antenna,
	input  logic [IDX_W-1:0]         read_index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CNT_W-1:0]         read_value,
	output logic [CNT_W-1:0]         total_frames,
	output logic signed [RSSI_W-1:0] rssi_lowest,
	output logic signed [RSSI_W-1:0] rssi_highest,
	output logic                     rssi_valid
);

	fsc_ctrl_t ctrl;

	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	fsc_datapath #(
		.INTERVAL_BINS (INTERVAL_BINS),
		.RATE_CODES    (RATE_CODES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.command      (command),
		.timestamp_us (timestamp_us),
		.rssi_dbm     (rssi_dbm),
		.signal_mode  (signal_mode),
		.rate_code    (rate_code),
		.antenna      (antenna),
		.read_index   (read_index),
		.read_value   (read_value),
		.total_frames (total_frames),
		.rssi_lowest  (rssi_lowest),
		.rssi_highest (rssi_highest),
		.rssi_valid   (rssi_valid)
	);

endmodule

// ===== rtl/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsc_ctrl: controller of the frame statistics collector
// Two-state sequencer: take a request, then commit it once the result
// register is free or being emptied. Owns both handshakes.
// ----------------------------------------------------------------------------
module fsc_ctrl import fsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output fsc_ctrl_t ctrl
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic state_q;
	logic state_nxt;
	logic out_valid_q;
	logic out_free;

	// result register may be written when empty or emptied this cycle
	assign out_free     = !out_valid_q || !out_stall;
	assign in_stall     = (state_q != ST_IDLE);
	assign ctrl.capture = (state_q == ST_IDLE) && in_valid;
	assign ctrl.commit  = (state_q == ST_UPDATE) && out_free;
	assign out_valid    = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/fsc_rate_store.sv =====
// ----------------------------------------------------------------------------
// fsc_rate_store: per-rate frame counters
// One-port-read, one-port-write memory with registered read data and a
// valid bit per entry, so a clear takes effect at once.
// ----------------------------------------------------------------------------
module fsc_rate_store import fsc_pkg::*; #(
	parameter  int DEPTH = 256,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [CNT_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [CNT_W-1:0] wr_data,
	input  logic             clear
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] rd_word_s1;
	logic             rd_valid_s1;

	// memory array
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_word_s1 <= mem[rd_addr];
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// entry valid bits; an entry never written since clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_s1 ? rd_word_s1 : '0;

endmodule

// ===== rtl/fsc_datapath.sv =====
// ----------------------------------------------------------------------------
// fsc_datapath: statistics datapath
// Gap computation at capture, gap binning and counter updates at commit,
// read selection and the result register.
// ----------------------------------------------------------------------------
module fsc_datapath import fsc_pkg::*; #(
	parameter int INTERVAL_BINS = 10,
	parameter int RATE_CODES    = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fsc_ctrl_t                ctrl,
	input  logic [CMD_W-1:0]         command,
	input  logic [TIME_W-1:0]        timestamp_us,
	input  logic signed [RSSI_W-1:0] rssi_dbm,
	input  logic [MODE_W-1:0]        signal_mode,
	input  logic [RATE_W-1:0]        rate_code,
	input  logic                     antenna,
	input  logic [IDX_W-1:0]         read_index,
	output logic [CNT_W-1:0]         read_value,
	output logic [CNT_W-1:0]         total_frames,
	output logic signed [RSSI_W-1:0] rssi_lowest,
	output logic signed [RSSI_W-1:0] rssi_highest,
	output logic                     rssi_valid
);

	localparam int BIN_W     = $clog2(INTERVAL_BINS);
	localparam int RATE_AW   = $clog2(RATE_CODES);
	localparam int MODE_BASE = INTERVAL_BINS;
	localparam int ANT_BASE  = INTERVAL_BINS + MODE_N;
	localparam int RATE_BASE = INTERVAL_BINS + MODE_N + ANT_N;
	localparam int IDX_END   = RATE_BASE + RATE_CODES;

	// statistics state
	logic [TIME_W-1:0]        prev_time_q;
	logic                     awaiting_q;
	logic [CNT_W-1:0]         total_q;
	logic signed [RSSI_W-1:0] rmin_q;
	logic signed [RSSI_W-1:0] rmax_q;
	logic [CNT_W-1:0]         bins_q [INTERVAL_BINS];
	logic [CNT_W-1:0]         mode_q [MODE_N];
	logic [CNT_W-1:0]         ant_q  [ANT_N];

	// captured request
	logic [CMD_W-1:0]         cmd_s1;
	logic [TIME_W-1:0]        now_s1;
	logic [TIME_W-1:0]        gap_s1;
	logic signed [RSSI_W-1:0] rssi_s1;
	logic [MODE_W-1:0]        mode_s1;
	logic                     ant_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [RATE_AW-1:0]       rate_addr_s1;
	logic                     rate_in_s1;

	// result register
	logic [CNT_W-1:0]         read_value_q;
	logic [CNT_W-1:0]         total_out_q;
	logic signed [RSSI_W-1:0] rmin_out_q;
	logic signed [RSSI_W-1:0] rmax_out_q;
	logic                     rvalid_out_q;

	logic [TIME_W-1:0]        prev_eff;
	logic [TIME_W:0]          diff_c;
	logic [TIME_W-1:0]        gap_c;
	logic [IDX_W-1:0]         rate_off_c;
	logic [RATE_AW-1:0]       rd_addr_c;
	logic [CNT_W-1:0]         rate_rd_data;
	logic                     do_record;
	logic                     do_clear;
	logic                     gap_hi;
	logic [BIN_W-1:0]         bin_sel;
	logic [IDX_W-1:0]         mode_off;
	logic [IDX_W-1:0]         ant_off;
	logic [CNT_W-1:0]         counter_sel;
	logic [CNT_W-1:0]         total_nxt;
	logic signed [RSSI_W-1:0] rmin_nxt;
	logic signed [RSSI_W-1:0] rmax_nxt;

	// gap since the previous frame, clamped at zero
	assign prev_eff = awaiting_q ? timestamp_us : prev_time_q;
	assign diff_c   = {1'b0, timestamp_us} - {1'b0, prev_eff};
	assign gap_c    = diff_c[TIME_W] ? '0 : diff_c[TIME_W-1:0];

	// rate counter address: the frame's rate, or the index of a read
	assign rate_off_c = read_index - IDX_W'(RATE_BASE);
	assign rd_addr_c  = (command == CMD_READ) ? rate_off_c[RATE_AW-1:0]
	                                          : rate_code[RATE_AW-1:0];

	// capture stage
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_s1       <= command;
			now_s1       <= timestamp_us;
			gap_s1       <= gap_c;
			rssi_s1      <= rssi_dbm;
			mode_s1      <= signal_mode;
			ant_s1       <= antenna;
			idx_s1       <= read_index;
			rate_addr_s1 <= rate_code[RATE_AW-1:0];
			rate_in_s1   <= ({1'b0, rate_code} < (RATE_W+1)'(RATE_CODES));
		end
	end

	assign do_record = ctrl.commit && (cmd_s1 == CMD_RECORD);
	assign do_clear  = ctrl.commit && (cmd_s1 == CMD_CLEAR);

	fsc_rate_store #(
		.DEPTH (RATE_CODES)
	) u_rate_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctrl.capture),
		.rd_addr (rd_addr_c),
		.rd_data (rate_rd_data),
		.wr_en   (do_record && rate_in_s1),
		.wr_addr (rate_addr_s1),
		.wr_data (rate_rd_data + CNT_W'(1)),
		.clear   (do_clear)
	);

	// gap binning: first bin whose threshold exceeds the gap, else the last
	assign gap_hi = |gap_s1[TIME_W-1:THR_W];
	always_comb begin
		bin_sel = BIN_W'(INTERVAL_BINS - 1);
		for (int i = INTERVAL_BINS - 2; i >= 0; i--) begin
			if (!gap_hi && (gap_s1[THR_W-1:0] < GAP_THR[i]))
				bin_sel = BIN_W'(i);
		end
	end

	// counter selection for a read
	assign mode_off = idx_s1 - IDX_W'(MODE_BASE);
	assign ant_off  = idx_s1 - IDX_W'(ANT_BASE);
	always_comb begin
		if (idx_s1 < IDX_W'(MODE_BASE))
			counter_sel = bins_q[idx_s1[BIN_W-1:0]];
		else if (idx_s1 < IDX_W'(ANT_BASE))
			counter_sel = mode_q[mode_off[MODE_W-1:0]];
		else if (idx_s1 < IDX_W'(RATE_BASE))
			counter_sel = ant_q[ant_off[0]];
		else if (idx_s1 < IDX_W'(IDX_END))
			counter_sel = rate_rd_data;
		else
			counter_sel = '0;
	end

	// totals and extremes after this request
	always_comb begin
		total_nxt = total_q;
		rmin_nxt  = rmin_q;
		rmax_nxt  = rmax_q;
		case (cmd_s1)
			CMD_RECORD: begin
				total_nxt = total_q + CNT_W'(1);
				if (rssi_s1 < rmin_q)
					rmin_nxt = rssi_s1;
				if (rssi_s1 > rmax_q)
					rmax_nxt = rssi_s1;
			end
			CMD_CLEAR: begin
				total_nxt = '0;
				rmin_nxt  = RSSI_MIN_INIT;
				rmax_nxt  = RSSI_MAX_INIT;
			end
			default: ;
		endcase
	end

	// statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			awaiting_q  <= 1'b1;
			total_q     <= '0;
			rmin_q      <= RSSI_MIN_INIT;
			rmax_q      <= RSSI_MAX_INIT;
			for (int i = 0; i < INTERVAL_BINS; i++)
				bins_q[i] <= '0;
			for (int i = 0; i < MODE_N; i++)
				mode_q[i] <= '0;
			for (int i = 0; i < ANT_N; i++)
				ant_q[i] <= '0;
		end else if (ctrl.commit) begin
			total_q <= total_nxt;
			rmin_q  <= rmin_nxt;
			rmax_q  <= rmax_nxt;
			if (do_clear) begin
				prev_time_q <= '0;
				awaiting_q  <= 1'b1;
				for (int i = 0; i < INTERVAL_BINS; i++)
					bins_q[i] <= '0;
				for (int i = 0; i < MODE_N; i++)
					mode_q[i] <= '0;
				for (int i = 0; i < ANT_N; i++)
					ant_q[i] <= '0;
			end else if (do_record) begin
				prev_time_q <= now_s1;
				awaiting_q  <= 1'b0;
				for (int i = 0; i < INTERVAL_BINS; i++)
					if (bin_sel == BIN_W'(i))
						bins_q[i] <= bins_q[i] + CNT_W'(1);
				for (int i = 0; i < MODE_N; i++)
					if (mode_s1 == MODE_W'(i))
						mode_q[i] <= mode_q[i] + CNT_W'(1);
				for (int i = 0; i < ANT_N; i++)
					if (ant_s1 == 1'(i))
						ant_q[i] <= ant_q[i] + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			read_value_q <= (cmd_s1 == CMD_READ) ? counter_sel : '0;
			total_out_q  <= total_nxt;
			rmin_out_q   <= rmin_nxt;
			rmax_out_q   <= rmax_nxt;
			rvalid_out_q <= (rmin_nxt <= rmax_nxt);
		end
	end

	assign read_value   = read_value_q;
	assign total_frames = total_out_q;
	assign rssi_lowest  = rmin_out_q;
	assign rssi_highest = rmax_out_q;
	assign rssi_valid   = rvalid_out_q;

endmodule

// ===== rtl/fsc_checker.sv =====
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks of the frame statistics collector
// Watches the top level's channels and result fields; bound to the top.
// ----------------------------------------------------------------------------
module fsc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [31:0]       read_value,
	input logic [31:0]       total_frames,
	input logic signed [7:0] rssi_lowest,
	input logic signed [7:0] rssi_highest,
	input logic              rssi_valid
);

	// one request at a time: a taken request blocks the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while the previous one is still in work");

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value)
			&& $stable(total_frames) && $stable(rssi_lowest) && $stable(rssi_highest))
		else $error("stalled result changed");

	// valid flag agrees with the extremes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rssi_valid == (rssi_lowest <= rssi_highest)))
		else $error("rssi_valid inconsistent with the extremes");

	// with no frame seen the extremes sit at their cleared values
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rssi_valid |-> (rssi_lowest == 8'sh7F) && (rssi_highest == 8'sh80))
		else $error("extremes not at cleared values without a frame");

endmodule

bind frame_statistics_collector_unit fsc_checker u_fsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.read_value   (read_value),
	.total_frames (total_frames),
	.rssi_lowest  (rssi_lowest),
	.rssi_highest (rssi_highest),
	.rssi_valid   (rssi_valid)
);
